@@ rtl/core/tkcws_pkg.sv @@
package tkcws_pkg;

  localparam int unsigned WORDS    = 4096;
  localparam int unsigned DIM      = 256;
  localparam int unsigned WORD_LEN = 64;
  localparam int unsigned TOP      = 5;

  localparam int unsigned ENTRY_W = 12;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned WIDX_W  = $clog2(WORDS);
  localparam int unsigned DIDX_W  = $clog2(DIM);
  localparam int unsigned CIDX_W  = $clog2(WORD_LEN);
  localparam int unsigned QLEN_W  = $clog2(WORD_LEN + 2);
  localparam int unsigned WCNT_W  = $clog2(WORDS + 1);
  localparam int unsigned VLEN_W  = $clog2(DIM + 1);
  localparam int unsigned RANK_W  = 3;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [31:0] SCORE_ONE     = 32'sd1073741824;
  localparam logic [31:0] SCORE_MINUS_1 = -32'sd1073741824;

  typedef enum logic [1:0] {
    ACT_LOAD_CHAR = 2'd0,
    ACT_LOAD_COMP = 2'd1,
    ACT_QUERY     = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD_COUNT    = 1'b0,
    REG_VECTOR_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]   position;
    logic [7:0]         char_code;
    logic signed [15:0] component;
    logic               final_char;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [ENTRY_W-1:0] match_index;
    logic signed [31:0] score;
    logic               slot_filled;
    logic               found;
    logic               last;
  } out_item_t;

endpackage

@@ rtl/core/top_k_cosine_word_search_top.sv @@
// A load request (character or component) is written as it is accepted.
// A query character without the final flag is buffered, and the query is
// trimmed at its first zero byte as it arrives. The final character starts
// a search that holds in_ready low: a check of the query length, then the
// query is compared against each entry in use one character at a time
// (a request state, then a compare state, through the single read port
// of the word memory). Without a match a single not-found result is sent.
// Otherwise every other entry is scored by one shared multiply-accumulate
// that reads both components of each dimension in turn (both vectors
// share one memory port and the product is registered), then finishes
// the sum and makes an ordered insert into the TOP best. The TOP results
// then leave one per cycle through an output register while out_ready is
// high. Configuration should be written only while no search is running.
module top_k_cosine_word_search_top
  import tkcws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_QSCAN, S_MREQ, S_MCMP, S_NOTFOUND,
    S_VREQA, S_VREQB, S_VACC, S_INS, S_EMIT, S_DRAIN
  } state_t;

  localparam int unsigned WADDR_W = WIDX_W + CIDX_W;
  localparam int unsigned VADDR_W = WIDX_W + DIDX_W;

  logic [7:0]         word_mem [WORDS*WORD_LEN];
  logic signed [15:0] vec_mem  [WORDS*DIM];
  logic [7:0]         wrd_q;
  logic signed [15:0] vec_q;

  logic [7:0]  qbuf_r [WORD_LEN];
  logic [7:0]  qch_r;
  logic [QLEN_W-1:0] qlen_r;
  logic [QLEN_W-1:0] qeff_r;
  logic [QLEN_W-1:0] qtrim_r;
  logic              qzero_r;

  logic [WCNT_W-1:0] wcount_r;
  logic [VLEN_W-1:0] vlen_r;

  state_t state_r;
  logic [WCNT_W-1:0]  w_r;
  logic [WIDX_W-1:0]  hit_r;
  logic [QLEN_W-1:0]  ci_r;
  logic [VLEN_W-1:0]  di_r;
  logic signed [15:0] a_r;
  logic signed [31:0] prod_r;
  logic               prod_v_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0] cand_r;
  logic [WIDX_W-1:0]  cand_i_r;
  logic [RANK_W-1:0]  slot_r;
  logic               placed_r;

  logic signed [31:0] bs_r [TOP];
  logic [WIDX_W-1:0]  bi_r [TOP];
  logic               bv_r [TOP];

  logic       out_valid_r;
  out_item_t  out_r;

  logic [WCNT_W-1:0] wc_eff;
  logic [VLEN_W-1:0] vl_eff;
  assign wc_eff = (wcount_r > WCNT_W'(WORDS)) ? WCNT_W'(WORDS) : wcount_r;
  assign vl_eff = (vlen_r > VLEN_W'(DIM)) ? VLEN_W'(DIM) : vlen_r;

  logic in_fire;
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Single read port per memory; address is chosen by the sequencer.
  logic [WADDR_W-1:0] waddr;
  logic [VADDR_W-1:0] vaddr;
  logic [WIDX_W-1:0]  widx;
  assign widx  = w_r[WIDX_W-1:0];
  assign waddr = {widx, ci_r[CIDX_W-1:0]};
  assign vaddr = (state_r == S_VREQA) ? {hit_r, di_r[DIDX_W-1:0]}
                                      : {widx, di_r[DIDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == ACT_LOAD_CHAR &&
        32'(in_data.position) < WORD_LEN && 32'(in_data.entry) < WORDS) begin
      word_mem[{in_data.entry[WIDX_W-1:0], in_data.position[CIDX_W-1:0]}]
        <= in_data.char_code;
    end
    wrd_q <= word_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == ACT_LOAD_COMP &&
        32'(in_data.position) < DIM && 32'(in_data.entry) < WORDS) begin
      vec_mem[{in_data.entry[WIDX_W-1:0], in_data.position[DIDX_W-1:0]}]
        <= in_data.component;
    end
    vec_q <= vec_mem[vaddr];
  end

  // The query character is read alongside the stored one, so both arrive
  // in the compare cycle.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == ACT_QUERY && 32'(qlen_r) < WORD_LEN) begin
      qbuf_r[qlen_r[CIDX_W-1:0]] <= in_data.char_code;
    end
    qch_r <= qbuf_r[ci_r[CIDX_W-1:0]];
  end

  // Saturated score of the finished accumulator.
  logic signed [31:0] sat_score;
  always_comb begin
    if (acc_r > ACC_W'(signed'(SCORE_ONE))) sat_score = SCORE_ONE;
    else if (acc_r < -ACC_W'(signed'(SCORE_ONE))) sat_score = SCORE_MINUS_1;
    else sat_score = acc_r[31:0];
  end

  // Ordered insert: the candidate takes the first slot that is empty or
  // beaten, then the displaced entries carry down until an empty or the last slot.
  logic ins_take;
  logic ins_done;
  assign ins_take = placed_r || !bv_r[slot_r] || (cand_r > bs_r[slot_r]);
  assign ins_done = (slot_r == RANK_W'(TOP - 1)) || (ins_take && !bv_r[slot_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qlen_r      <= '0;
      qzero_r     <= 1'b0;
      wcount_r    <= WCNT_W'(WORDS);
      vlen_r      <= VLEN_W'(DIM);
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
      for (int i = 0; i < TOP; i++) bv_r[i] <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WORD_COUNT:    wcount_r <= cfg_data[WCNT_W-1:0];
          REG_VECTOR_LENGTH: vlen_r   <= cfg_data[VLEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_EMIT && state_r != S_NOTFOUND) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && in_data.action == ACT_QUERY) begin
            if (32'(qlen_r) < WORD_LEN) begin
              qlen_r <= qlen_r + 1'b1;
              if (!qzero_r && in_data.char_code == 8'd0) begin
                qzero_r <= 1'b1;
                qtrim_r <= qlen_r;
              end
            end else begin
              qlen_r <= QLEN_W'(WORD_LEN + 1);
            end
            // The effective length stops at the first zero byte.
            if (in_data.final_char) begin
              if (32'(qlen_r) >= WORD_LEN) qeff_r <= QLEN_W'(WORD_LEN + 1);
              else if (qzero_r) qeff_r <= qtrim_r;
              else if (in_data.char_code == 8'd0) qeff_r <= qlen_r;
              else qeff_r <= qlen_r + 1'b1;
              state_r <= S_QSCAN;
            end
          end
        end
        S_QSCAN: begin
          qlen_r  <= '0;
          qzero_r <= 1'b0;
          w_r <= '0; ci_r <= '0;
          if (32'(qeff_r) > WORD_LEN) begin
            state_r <= S_NOTFOUND;
          end else begin
            state_r <= (wc_eff == '0) ? S_NOTFOUND : S_MREQ;
          end
        end
        S_MREQ: state_r <= S_MCMP;
        S_MCMP: begin
          // Past the query: the stored word must end here or be full length.
          if (ci_r == qeff_r) begin
            if (32'(qeff_r) == WORD_LEN || wrd_q == 8'd0) begin
              hit_r <= widx;
              for (int i = 0; i < TOP; i++) bv_r[i] <= 1'b0;
              w_r <= '0; di_r <= '0; acc_r <= '0;
              state_r <= S_VREQA;
            end else begin
              ci_r <= '0; w_r <= w_r + 1'b1;
              state_r <= (w_r + 1'b1 == wc_eff) ? S_NOTFOUND : S_MREQ;
            end
          end else if (wrd_q != qch_r) begin
            ci_r <= '0; w_r <= w_r + 1'b1;
            state_r <= (w_r + 1'b1 == wc_eff) ? S_NOTFOUND : S_MREQ;
          end else begin
            ci_r <= ci_r + 1'b1;
            state_r <= S_MREQ;
          end
        end
        S_NOTFOUND: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r       <= '{rank: '0, match_index: '0, score: '0,
                             slot_filled: 1'b0, found: 1'b0, last: 1'b1};
            state_r     <= S_IDLE;
          end
        end
        S_VREQA: begin
          if (w_r == wc_eff) begin
            slot_r <= '0;
            state_r <= S_EMIT;
          end else if (widx == hit_r) begin
            w_r <= w_r + 1'b1;
          end else if (di_r == vl_eff) begin
            state_r <= S_VACC;
          end else begin
            state_r <= S_VREQB;
          end
        end
        S_VREQB: begin
          a_r <= vec_q;
          state_r <= S_VACC;
        end
        S_VACC: begin
          // Shared multiplier, registered, then added on the next pass.
          if (prod_v_r) acc_r <= acc_r + ACC_W'(prod_r);
          prod_v_r <= (di_r != vl_eff);
          if (di_r != vl_eff) begin
            prod_r   <= a_r * vec_q;
            di_r     <= di_r + 1'b1;
            state_r  <= S_VREQA;
          end else if (!prod_v_r) begin
            cand_r   <= sat_score;
            cand_i_r <= widx;
            slot_r   <= '0;
            placed_r <= 1'b0;
            state_r  <= S_INS;
          end
        end
        S_INS: begin
          if (ins_take) begin
            bs_r[slot_r] <= cand_r;
            bi_r[slot_r] <= cand_i_r;
            bv_r[slot_r] <= 1'b1;
            cand_r   <= bs_r[slot_r];
            cand_i_r <= bi_r[slot_r];
            placed_r <= 1'b1;
          end
          if (ins_done) begin
            w_r <= w_r + 1'b1; di_r <= '0; acc_r <= '0;
            state_r <= S_VREQA;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r <= '{rank: slot_r,
                       match_index: bv_r[slot_r] ? ENTRY_W'(bi_r[slot_r]) : ENTRY_W'(0),
                       score: bv_r[slot_r] ? bs_r[slot_r] : 32'sd0,
                       slot_filled: bv_r[slot_r],
                       found: 1'b1,
                       last: (slot_r == RANK_W'(TOP - 1))};
            if (slot_r == RANK_W'(TOP - 1)) state_r <= S_IDLE;
            else slot_r <= slot_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_ready;
  endproperty
  a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_data));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  property p_rank_top;
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> (32'(out_data.rank) < TOP);
  endproperty
  a_rank_top: assert property (p_rank_top) else $error("rank out of range");

  property p_nf_last;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && !out_data.found) |-> (out_data.last && !out_data.slot_filled);
  endproperty
  a_nf_last: assert property (p_nf_last) else $error("bad not-found result");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import tkcws_pkg::*;

  typedef bit [7:0] str_t[$];

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned USED_ENTRIES = 6;
  localparam int unsigned VEC_USED = 8;

  // Golden model of the search plus the queue of results still owed by the block.
  class search_scoreboard;
    bit [7:0] word_mem [WORDS*WORD_LEN];
    shortint  vec_mem [WORDS*DIM];
    bit [7:0] qbuf [WORD_LEN];
    int unsigned qlen;
    int unsigned wcount;
    int unsigned vlen;
    out_item_t pending[$];
    int mismatches;
    int unexpected;

    function new();
      wcount = 4096;
      vlen = 256;
      qlen = 0;
      mismatches = 0;
      unexpected = 0;
    endfunction

    function void set_reg(cfg_reg_t r, int unsigned v);
      if (r == REG_WORD_COUNT) begin
        wcount = v & 32'h1FFF;
      end else begin
        vlen = v & 32'h1FF;
      end
    endfunction

    function str_t word_of(int unsigned e);
      str_t s;
      for (int i = 0; i < WORD_LEN; i++) begin
        if (word_mem[e*WORD_LEN+i] == 0) break;
        s = {s, word_mem[e*WORD_LEN+i]};
      end
      return s;
    endfunction

    function bit word_hit(int unsigned w, int unsigned n);
      for (int i = 0; i < n; i++) begin
        if (word_mem[w*WORD_LEN+i] != qbuf[i]) return 0;
      end
      return (n == WORD_LEN) || (word_mem[w*WORD_LEN+n] == 0);
    endfunction

    function longint dot(int unsigned a, int unsigned b, int unsigned n);
      longint acc;
      acc = 0;
      for (int i = 0; i < n; i++) begin
        acc += longint'(vec_mem[a*DIM+i]) * longint'(vec_mem[b*DIM+i]);
      end
      if (acc > 64'sd1073741824) acc = 64'sd1073741824;
      if (acc < -64'sd1073741824) acc = -64'sd1073741824;
      return acc;
    endfunction

    function void add_expect(int k, int idx, longint s, bit filled, bit fnd, bit lst);
      out_item_t r;
      r.rank = k[RANK_W-1:0];
      r.match_index = idx[ENTRY_W-1:0];
      r.score = s[31:0];
      r.slot_filled = filled;
      r.found = fnd;
      r.last = lst;
      pending = {pending, r};
    endfunction

    function void run_search();
      int unsigned wc, vl, n, hit;
      bit fnd, placed;
      longint s;
      longint bs [TOP];
      int unsigned bi [TOP];
      bit bv [TOP];
      wc = (wcount > WORDS) ? WORDS : wcount;
      vl = (vlen > DIM) ? DIM : vlen;
      n = qlen;
      hit = 0;
      fnd = 0;
      if (n <= WORD_LEN) begin
        for (int i = 0; i < n; i++) begin
          if (qbuf[i] == 0) begin
            n = i;
            break;
          end
        end
        for (int w = 0; w < wc; w++) begin
          if (word_hit(w, n)) begin
            hit = w;
            fnd = 1;
            break;
          end
        end
      end
      qlen = 0;
      if (!fnd) begin
        add_expect(0, 0, 0, 0, 0, 1);
        return;
      end
      for (int a = 0; a < TOP; a++) begin
        bs[a] = -64'sd1073741824;
        bi[a] = 0;
        bv[a] = 0;
      end
      for (int w = 0; w < wc; w++) begin
        if (w == hit) continue;
        s = dot(hit, w, vl);
        placed = 0;
        for (int a = 0; a < TOP && !placed; a++) begin
          if (!bv[a] || s > bs[a]) begin
            for (int d = TOP - 1; d > a; d--) begin
              bs[d] = bs[d-1];
              bi[d] = bi[d-1];
              bv[d] = bv[d-1];
            end
            bs[a] = s;
            bi[a] = w;
            bv[a] = 1;
            placed = 1;
          end
        end
      end
      for (int k = 0; k < TOP; k++) begin
        if (bv[k]) add_expect(k, bi[k], bs[k], 1, 1, k == TOP - 1);
        else add_expect(k, 0, 0, 0, 1, k == TOP - 1);
      end
    endfunction

    function void note_request(in_item_t it);
      case (it.action)
        ACT_LOAD_CHAR: begin
          if (it.position < WORD_LEN) word_mem[it.entry*WORD_LEN+it.position] = it.char_code;
        end
        ACT_LOAD_COMP: begin
          if (it.position < DIM) vec_mem[it.entry*DIM+it.position] = it.component;
        end
        ACT_QUERY: begin
          if (qlen < WORD_LEN) begin
            qbuf[qlen] = it.char_code;
            qlen++;
          end else begin
            qlen = WORD_LEN + 1;
          end
          if (it.final_char) run_search();
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        unexpected++;
        if (unexpected <= 10) begin
          $display("Unexpected result: rank %0d index %0d score %0d", got.rank,
                   got.match_index, got.score);
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected rank %0d idx %0d score %0d fill %0b found %0b last %0b",
                   want.rank, want.match_index, want.score, want.slot_filled, want.found,
                   want.last);
          $display("          actual   rank %0d idx %0d score %0d fill %0b found %0b last %0b",
                   got.rank, got.match_index, got.score, got.slot_filled, got.found,
                   got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  search_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode = 0;
  int mode_left = 0;

  top_k_cosine_word_search_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL top_k_cosine_word_search_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: changes its stall pattern every so often, and holds off for a
  // long stretch whenever the stimulus asks for it.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 2500;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left = mode_left - 1;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic in_item_t mk(action_t a, int e, int p, int c, int comp, int f);
    in_item_t it;
    it.action = a;
    it.entry = e[ENTRY_W-1:0];
    it.position = p[POS_W-1:0];
    it.char_code = c[7:0];
    it.component = comp[15:0];
    it.final_char = f[0];
    return it;
  endfunction

  function automatic int rand_comp();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic send_req(in_item_t it);
    int unsigned g;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_char(int e, int p, bit [7:0] c);
    send_req(mk(ACT_LOAD_CHAR, e, p, int'(c), int'($urandom), int'($urandom_range(0, 1))));
  endtask

  task automatic load_comp(int e, int p, int v);
    send_req(mk(ACT_LOAD_COMP, e, p, int'($urandom), v, int'($urandom_range(0, 1))));
  endtask

  task automatic load_word(int e, str_t s);
    for (int i = 0; i < s.size(); i++) load_char(e, i, s[i]);
    if (s.size() < WORD_LEN) load_char(e, s.size(), 8'h00);
  endtask

  task automatic send_query(str_t s);
    if (s.size() == 0) s = {s, 8'h00};
    for (int i = 0; i < s.size(); i++) begin
      send_req(mk(ACT_QUERY, int'($urandom), int'($urandom), int'(s[i]), int'($urandom),
                  int'(i == s.size() - 1)));
    end
  endtask

  function automatic str_t rand_word(int n);
    str_t s;
    for (int i = 0; i < n; i++) s = {s, 8'(8'h61 + $urandom_range(0, 3))};
    return s;
  endfunction

  // Waits until every owed result is back, plus a margin for loads in flight.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_regs(int wc, int vl);
    cfg_we <= 1'b1;
    cfg_index <= REG_WORD_COUNT;
    cfg_data <= CFG_W'(wc);
    @(posedge clk);
    cfg_index <= REG_VECTOR_LENGTH;
    cfg_data <= CFG_W'(vl);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_WORD_COUNT, wc);
    sb.set_reg(REG_VECTOR_LENGTH, vl);
  endtask

  task automatic fill_entries();
    str_t s;
    str_t w1;
    for (int e = 0; e < USED_ENTRIES; e++) begin
      case (e)
        3: s = w1;
        4: s = rand_word(WORD_LEN);
        5: s = {};
        default: s = rand_word($urandom_range(1, 4));
      endcase
      if (e == 1) w1 = s;
      // Each word shorter than WORD_LEN is written up to and including its terminator.
      load_word(e, s);
    end
    for (int e = 0; e < USED_ENTRIES; e++) begin
      for (int d = 0; d < VEC_USED; d++) begin
        if (e == 0 || e == USED_ENTRIES - 1) load_comp(e, d, -32768);
        else if (e == 4) load_comp(e, d, int'(sb.vec_mem[2*DIM+d]));
        else load_comp(e, d, rand_comp());
      end
    end
  endtask

  task automatic random_op(int wc);
    int k;
    int e;
    str_t s;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      send_query(sb.word_of($urandom_range(0, wc - 1)));
    end else if (k < 45) begin
      s = rand_word($urandom_range(1, 4));
      if ($urandom_range(0, 4) == 0) s[$urandom_range(0, s.size() - 1)] = 8'h00;
      send_query(s);
    end else if (k < 47) begin
      send_query(rand_word(WORD_LEN + $urandom_range(1, 4)));
    end else if (k < 62) begin
      e = $urandom_range(0, USED_ENTRIES - 1);
      load_word(e, rand_word(($urandom_range(0, 9) == 0) ? WORD_LEN : $urandom_range(0, 5)));
    end else if (k < 80) begin
      e = $urandom_range(0, USED_ENTRIES - 1);
      repeat ($urandom_range(1, 6)) begin
        load_comp(e, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 15), rand_comp());
      end
    end else if (k < 97) begin
      send_req(mk($urandom_range(0, 1) ? ACT_LOAD_CHAR : ACT_LOAD_COMP,
                  int'($urandom_range(USED_ENTRIES, 4095)), int'($urandom_range(0, 255)),
                  int'($urandom_range(0, 255)), rand_comp(), int'($urandom_range(0, 1))));
    end else begin
      send_req(mk(ACT_NONE, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                  int'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    str_t s;
    int unsigned stop_at;
    int wc;
    int vl;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fill_entries();
    load_char(4095, 255, 8'hFF);
    load_comp(4095, 255, -32768);
    load_comp(4095, 0, 32767);
    send_req(mk(ACT_NONE, 4095, 255, 255, 32767, 1));
    settle();

    // Out-of-range register values, exercised with loads only.
    set_regs(8191, 511);
    load_char(4095, 63, 8'h7A);
    load_comp(4094, 255, 12345);
    settle();

    set_regs(USED_ENTRIES, VEC_USED);
    send_query(sb.word_of(1));
    send_query(sb.word_of(0));
    send_query({8'h00});
    send_query(sb.word_of(4));
    send_query({8'h7A, 8'h7A});
    s = sb.word_of(2);
    s = {s, 8'h00};
    s = {s, 8'h78};
    send_query(s);
    send_query(rand_word(WORD_LEN + 1));
    settle();

    set_regs(0, 5);
    send_query(sb.word_of(1));
    settle();
    set_regs(1, 0);
    send_query(sb.word_of(0));
    settle();
    set_regs(3, 0);
    send_query(sb.word_of(2));
    settle();

    stop_at = items_sent + RANDOM_ITEMS;
    for (int phase = 0; phase < 6; phase++) begin
      wc = $urandom_range(1, USED_ENTRIES);
      case ($urandom_range(0, 5))
        0: vl = VEC_USED;
        1: vl = 0;
        default: vl = $urandom_range(1, VEC_USED);
      endcase
      set_regs(wc, vl);
      if (phase == 2) begin
        hold_req++;
        repeat (3) send_query(sb.word_of($urandom_range(0, wc - 1)));
      end
      while (items_sent < stop_at - (5 - phase) * RANDOM_ITEMS / 6) random_op(wc);
      settle();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0) begin
      $display("PASS top_k_cosine_word_search_top");
    end else begin
      $display("FAIL top_k_cosine_word_search_top");
    end
    $finish;
  end

endmodule
